// ===== rtl/sarcl_pkg.sv =====
// Package for the set-associative read cache with LRU replacement.
// Holds field widths, request and size codes, register indexes and defaults.
// No dependencies.
package sarcl_pkg;

  localparam int ADDR_W      = 9;
  localparam int WORD_W      = 32;
  localparam int LINE_BYTES  = 8;
  localparam int LINE_W      = 8 * LINE_BYTES;
  localparam int OFF_W       = 3;
  localparam int BLOCK_W     = ADDR_W - OFF_W;
  localparam int TAG_W       = 6;
  localparam int SIZE_W      = 2;
  localparam int COST_W      = 8;
  localparam int CFG_IDX_W   = 1;

  localparam int NUM_SETS_DEF  = 2;
  localparam int NUM_WAYS_DEF  = 2;
  localparam int MEM_WORDS_DEF = 128;

  localparam logic REQ_PRELOAD = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_COST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_COST   = 1'b1;

  localparam logic [COST_W-1:0] CACHE_COST_RST = 8'd1;
  localparam logic [COST_W-1:0] MEM_COST_RST   = 8'd100;

endpackage

// ===== rtl/set_assoc_read_cache_lru_core.sv =====
// Top level of the set-associative read cache with LRU replacement.
// Depends on sarcl_pkg for widths, codes and default parameters.
//
// The block takes one item per clock (busy_o never rises). Each item passes a read
// stage, which reads both words of the addressed block from the backing memory,
// which has one write port and two read ports with registered data, then a lookup
// stage, which looks up the tags, picks the victim way and updates the line, its
// stamp and the counters while the result is registered. done_o marks each result for
// exactly one cycle and cannot be held off, so the receiver must take it then.
// A preload writes its word at the transfer edge, so a read that follows in the
// next cycle already sees it. No clearing pass runs after reset. Configuration
// writes are always taken; write them only while no item is in flight.
module set_assoc_read_cache_lru_core #(
  parameter int NUM_SETS  = sarcl_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS  = sarcl_pkg::NUM_WAYS_DEF,
  parameter int MEM_WORDS = sarcl_pkg::MEM_WORDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               req_type_i,
  input  logic [sarcl_pkg::ADDR_W-1:0]       byte_address_i,
  input  logic [sarcl_pkg::SIZE_W-1:0]       access_size_i,
  input  logic [sarcl_pkg::WORD_W-1:0]       preload_word_i,
  output logic                               done_o,
  output logic [sarcl_pkg::WORD_W-1:0]       read_data_o,
  output logic                               was_hit_o,
  output logic [sarcl_pkg::WORD_W-1:0]       hit_total_o,
  output logic [sarcl_pkg::WORD_W-1:0]       miss_total_o,
  output logic [sarcl_pkg::WORD_W-1:0]       byte_total_o,
  output logic [sarcl_pkg::WORD_W-1:0]       cycle_total_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sarcl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sarcl_pkg::COST_W-1:0]       cfg_data_i
);

  localparam int WordW   = sarcl_pkg::WORD_W;
  localparam int LineW   = sarcl_pkg::LINE_W;
  localparam int TagW    = sarcl_pkg::TAG_W;
  localparam int BlockW  = sarcl_pkg::BLOCK_W;
  localparam int OffW    = sarcl_pkg::OFF_W;
  localparam int SizeW   = sarcl_pkg::SIZE_W;
  localparam int CostW   = sarcl_pkg::COST_W;
  localparam int WidxW   = sarcl_pkg::ADDR_W - 2;
  localparam int NumBlk  = 1 << BlockW;
  localparam int NumWidx = 1 << WidxW;
  localparam int SetW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WayW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int MemAw   = $clog2(MEM_WORDS);

  typedef struct packed {
    logic             req;
    logic [OffW-1:0]  off;
    logic [SizeW-1:0] size;
    logic [SetW-1:0]  set;
    logic [TagW-1:0]  tag;
  } s1_item_t;

  // ---------------------------------------------------------------- config
  logic [CostW-1:0] cache_cost_q, mem_cost_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_cost_q <= sarcl_pkg::CACHE_COST_RST;
      mem_cost_q   <= sarcl_pkg::MEM_COST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sarcl_pkg::CFG_CACHE_COST: cache_cost_q <= cfg_data_i;
        sarcl_pkg::CFG_MEM_COST:   mem_cost_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- tables
  // Set and tag of each block number, and word index modulo the memory depth.
  logic [SetW-1:0]  set_lut  [NumBlk];
  logic [TagW-1:0]  tag_lut  [NumBlk];
  logic [MemAw-1:0] widx_lut [NumWidx];

  for (genvar b = 0; b < NumBlk; b++) begin : g_blk_lut
    assign set_lut[b] = SetW'(b % NUM_SETS);
    assign tag_lut[b] = TagW'(b / NUM_SETS);
  end

  for (genvar i = 0; i < NumWidx; i++) begin : g_widx_lut
    assign widx_lut[i] = MemAw'(i % MEM_WORDS);
  end

  // ---------------------------------------------------------------- stage 0
  logic              accept;
  logic [BlockW-1:0] in_block;
  logic [MemAw-1:0]  wr_idx, rd0_idx, rd1_idx;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign in_block = byte_address_i[sarcl_pkg::ADDR_W-1:OffW];
  assign wr_idx   = widx_lut[byte_address_i[sarcl_pkg::ADDR_W-1:2]];
  assign rd0_idx  = widx_lut[{in_block, 1'b0}];
  assign rd1_idx  = widx_lut[{in_block, 1'b1}];

  logic [WordW-1:0] mem [MEM_WORDS];
  logic [WordW-1:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == sarcl_pkg::REQ_PRELOAD) begin
      mem[wr_idx] <= preload_word_i;
    end
    if (accept && req_type_i == sarcl_pkg::REQ_READ) begin
      rd0_q <= mem[rd0_idx];
      rd1_q <= mem[rd1_idx];
    end
  end

  logic     s1_valid_q;
  s1_item_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.req  <= req_type_i;
      s1_q.off  <= byte_address_i[OffW-1:0];
      s1_q.size <= access_size_i;
      s1_q.set  <= set_lut[in_block];
      s1_q.tag  <= tag_lut[in_block];
    end
  end

  // ---------------------------------------------------------------- lines
  logic [NUM_WAYS-1:0] valid_q [NUM_SETS];
  logic [TagW-1:0]     tag_q   [NUM_SETS][NUM_WAYS];
  logic [WordW-1:0]    stamp_q [NUM_SETS][NUM_WAYS];
  logic [LineW-1:0]    line_q  [NUM_SETS][NUM_WAYS];
  logic [WordW-1:0]    access_stamp_q;

  // ---------------------------------------------------------------- stage 1
  logic                s1_read;
  logic [NUM_WAYS-1:0] hit_vec, oldest;
  logic                hit;
  logic                free_found;
  logic [WayW-1:0]     hit_way, victim, way;
  logic [LineW-1:0]    line_sel, line_shift;
  logic [OffW-1:0]     off;
  logic [WordW-1:0]    mask, data;
  logic [2:0]          nbytes;
  logic [WordW-1:0]    stamp_new;

  assign s1_read   = s1_valid_q && s1_q.req == sarcl_pkg::REQ_READ;
  assign stamp_new = access_stamp_q + WordW'(1);

  // Way w is oldest if strictly below every lower way and not above any higher one.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      hit_vec[w] = valid_q[s1_q.set][w] && tag_q[s1_q.set][w] == s1_q.tag;
      oldest[w]  = 1'b1;
      for (int v = 0; v < NUM_WAYS; v++) begin
        if (v < w && !(stamp_q[s1_q.set][w] < stamp_q[s1_q.set][v])) begin
          oldest[w] = 1'b0;
        end
        if (v > w && stamp_q[s1_q.set][v] < stamp_q[s1_q.set][w]) begin
          oldest[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    victim     = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (hit_vec[w] && !hit) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
      if (!valid_q[s1_q.set][w] && !free_found) begin
        free_found = 1'b1;
        victim     = WayW'(w);
      end
    end
    if (!free_found) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (oldest[w]) begin
          victim = WayW'(w);
        end
      end
    end
  end

  assign way      = hit ? hit_way : victim;
  assign line_sel = hit ? line_q[s1_q.set][hit_way] : {rd1_q, rd0_q};

  always_comb begin
    unique case (s1_q.size)
      sarcl_pkg::SIZE_BYTE: begin
        off    = s1_q.off;
        mask   = WordW'(8'hFF);
        nbytes = 3'd1;
      end
      sarcl_pkg::SIZE_HALF: begin
        off    = {s1_q.off[2:1], 1'b0};
        mask   = WordW'(16'hFFFF);
        nbytes = 3'd2;
      end
      default: begin
        off    = {s1_q.off[2], 2'b00};
        mask   = '1;
        nbytes = 3'd4;
      end
    endcase
  end

  assign line_shift = line_sel >> {off, 3'b000};
  assign data       = line_shift[WordW-1:0] & mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
      access_stamp_q <= '0;
    end else if (s1_read) begin
      access_stamp_q <= stamp_new;
      if (!hit) begin
        valid_q[s1_q.set][way] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_read) begin
      stamp_q[s1_q.set][way] <= stamp_new;
      if (!hit) begin
        tag_q[s1_q.set][way]  <= s1_q.tag;
        line_q[s1_q.set][way] <= {rd1_q, rd0_q};
      end
    end
  end

  // ---------------------------------------------------------------- results
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q        <= 1'b0;
      hit_total_o   <= '0;
      miss_total_o  <= '0;
      byte_total_o  <= '0;
      cycle_total_o <= '0;
    end else begin
      done_q <= s1_valid_q;
      if (s1_read) begin
        byte_total_o <= byte_total_o + WordW'(nbytes);
        if (hit) begin
          hit_total_o   <= hit_total_o + WordW'(1);
          cycle_total_o <= cycle_total_o + WordW'(cache_cost_q);
        end else begin
          miss_total_o  <= miss_total_o + WordW'(1);
          cycle_total_o <= cycle_total_o + WordW'(cache_cost_q) + WordW'(mem_cost_q);
        end
      end
    end
  end

  // Preloads report zero data and no hit.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      read_data_o <= s1_read ? data : '0;
      was_hit_o   <= s1_read && hit;
    end
  end

  assign done_o = done_q;

  // ---------------------------------------------------------------- checks
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("transfer without a result two cycles later");

  a_one_hit_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_read |-> $onehot0(hit_vec))
    else $error("more than one way matches the tag");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && was_hit_o |->
      hit_total_o == $past(hit_total_o) + WordW'(1) && $stable(miss_total_o))
    else $error("hit counters out of step");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(cycle_total_o) && $stable(byte_total_o))
    else $error("counter moved without a result");

endmodule

// ===== tb/set_assoc_read_cache_lru_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for set_assoc_read_cache_lru_core: directed and random preload/read
// traffic against a built-in cache predictor, under several cost settings. Depends on sarcl_pkg.
module set_assoc_read_cache_lru_core_test;

  localparam int SETS       = sarcl_pkg::NUM_SETS_DEF;
  localparam int WAYS       = sarcl_pkg::NUM_WAYS_DEF;
  localparam int MEM_DEPTH  = sarcl_pkg::MEM_WORDS_DEF;
  localparam int NUM_BLOCKS = 1 << sarcl_pkg::BLOCK_W;
  localparam int TAGS       = NUM_BLOCKS / SETS;
  localparam int LATENCY    = 2;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 190;

  localparam logic [sarcl_pkg::SIZE_W-1:0] SIZE_WORD = 2'd2;
  localparam logic [sarcl_pkg::SIZE_W-1:0] SIZE_WIDE = 2'd3;

  typedef struct packed {
    logic                         req_type;
    logic [sarcl_pkg::ADDR_W-1:0] addr;
    logic [sarcl_pkg::SIZE_W-1:0] size;
    logic [sarcl_pkg::WORD_W-1:0] word;
  } cache_req_t;

  typedef struct packed {
    logic [sarcl_pkg::WORD_W-1:0] data;
    logic                         hit;
    logic [sarcl_pkg::WORD_W-1:0] hits;
    logic [sarcl_pkg::WORD_W-1:0] misses;
    logic [sarcl_pkg::WORD_W-1:0] bytes;
    logic [sarcl_pkg::WORD_W-1:0] cycles;
  } cache_resp_t;

  typedef struct packed {
    logic [sarcl_pkg::CFG_IDX_W-1:0] index;
    logic [sarcl_pkg::COST_W-1:0]    value;
  } cost_write_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            start_i        = 1'b0;
  logic                            req_type_i     = sarcl_pkg::REQ_PRELOAD;
  logic [sarcl_pkg::ADDR_W-1:0]    byte_address_i = '0;
  logic [sarcl_pkg::SIZE_W-1:0]    access_size_i  = sarcl_pkg::SIZE_BYTE;
  logic [sarcl_pkg::WORD_W-1:0]    preload_word_i = '0;
  logic                            cfg_valid_i    = 1'b0;
  logic [sarcl_pkg::CFG_IDX_W-1:0] cfg_index_i    = sarcl_pkg::CFG_CACHE_COST;
  logic [sarcl_pkg::COST_W-1:0]    cfg_data_i     = '0;
  logic                            busy_o;
  logic                            done_o;
  logic [sarcl_pkg::WORD_W-1:0]    read_data_o;
  logic                            was_hit_o;
  logic [sarcl_pkg::WORD_W-1:0]    hit_total_o;
  logic [sarcl_pkg::WORD_W-1:0]    miss_total_o;
  logic [sarcl_pkg::WORD_W-1:0]    byte_total_o;
  logic [sarcl_pkg::WORD_W-1:0]    cycle_total_o;
  logic                            cfg_ready_o;

  set_assoc_read_cache_lru_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .byte_address_i(byte_address_i),
    .access_size_i (access_size_i),
    .preload_word_i(preload_word_i),
    .done_o        (done_o),
    .read_data_o   (read_data_o),
    .was_hit_o     (was_hit_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o),
    .byte_total_o  (byte_total_o),
    .cycle_total_o (cycle_total_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: cache contents, backing memory image, counters and costs.
  logic                         way_valid [SETS][WAYS] = '{default: '0};
  logic [sarcl_pkg::TAG_W-1:0]  way_tag   [SETS][WAYS] = '{default: '0};
  logic [sarcl_pkg::WORD_W-1:0] way_stamp [SETS][WAYS] = '{default: '0};
  logic [sarcl_pkg::LINE_W-1:0] way_line  [SETS][WAYS] = '{default: '0};
  logic [sarcl_pkg::WORD_W-1:0] mem_image [MEM_DEPTH]  = '{default: '0};
  logic [sarcl_pkg::WORD_W-1:0] stamp_now    = '0;
  logic [sarcl_pkg::WORD_W-1:0] hits_so_far  = '0;
  logic [sarcl_pkg::WORD_W-1:0] misses_so_far = '0;
  logic [sarcl_pkg::WORD_W-1:0] bytes_so_far = '0;
  logic [sarcl_pkg::WORD_W-1:0] cycles_so_far = '0;
  logic [sarcl_pkg::COST_W-1:0] lookup_cost  = sarcl_pkg::CACHE_COST_RST;
  logic [sarcl_pkg::COST_W-1:0] miss_penalty = sarcl_pkg::MEM_COST_RST;

  cache_req_t  pending_reqs[$];
  cache_resp_t expected_resps[$];
  cost_write_t cost_writes[$];
  cache_req_t  driven_req;
  bit          word_loaded [MEM_DEPTH];
  bit          sender_gaps_on = 1'b1;
  int          gap_left;
  int          items_queued;
  int          results_seen;
  int          cost_writes_done;
  int          mismatch_count;
  int          elapsed_cycles;

  function automatic cache_resp_t cache_lookup(cache_req_t rq);
    cache_resp_t                  rs;
    int                           blk;
    int                           set_i;
    int                           way_i;
    int                           w;
    int                           off;
    int                           nbytes;
    logic [sarcl_pkg::TAG_W-1:0]  tag;
    logic [sarcl_pkg::LINE_W-1:0] mask;
    logic [sarcl_pkg::LINE_W-1:0] line;
    rs = '0;
    if (rq.req_type == sarcl_pkg::REQ_PRELOAD) begin
      mem_image[(rq.addr >> 2) % MEM_DEPTH] = rq.word;
    end else begin
      blk   = int'(rq.addr[sarcl_pkg::ADDR_W-1:sarcl_pkg::OFF_W]);
      set_i = blk % SETS;
      tag   = sarcl_pkg::TAG_W'(blk / SETS);
      case (rq.size)
        sarcl_pkg::SIZE_BYTE: begin
          nbytes = 1; mask = 64'hFF; off = int'(rq.addr) & 7;
        end
        sarcl_pkg::SIZE_HALF: begin
          nbytes = 2; mask = 64'hFFFF; off = int'(rq.addr) & 6;
        end
        default: begin
          nbytes = 4; mask = 64'hFFFF_FFFF; off = int'(rq.addr) & 4;
        end
      endcase
      stamp_now = stamp_now + 1;
      way_i = -1;
      for (w = 0; w < WAYS; w++)
        if (way_i < 0 && way_valid[set_i][w] && way_tag[set_i][w] == tag) way_i = w;
      if (way_i >= 0) begin
        rs.hit = 1'b1;
        hits_so_far = hits_so_far + 1;
        cycles_so_far = cycles_so_far + lookup_cost;
      end else begin
        // Fill the lowest invalid way, else the way with the oldest stamp.
        for (w = 0; w < WAYS; w++)
          if (way_i < 0 && !way_valid[set_i][w]) way_i = w;
        if (way_i < 0) begin
          way_i = 0;
          for (w = 1; w < WAYS; w++)
            if (way_stamp[set_i][w] < way_stamp[set_i][way_i]) way_i = w;
        end
        way_valid[set_i][way_i] = 1'b1;
        way_tag[set_i][way_i]   = tag;
        way_line[set_i][way_i]  = {mem_image[(blk * 2 + 1) % MEM_DEPTH],
                                   mem_image[(blk * 2) % MEM_DEPTH]};
        misses_so_far = misses_so_far + 1;
        cycles_so_far = cycles_so_far + lookup_cost + miss_penalty;
      end
      way_stamp[set_i][way_i] = stamp_now;
      bytes_so_far = bytes_so_far + nbytes;
      line = way_line[set_i][way_i];
      rs.data = sarcl_pkg::WORD_W'((line >> (8 * off)) & mask);
    end
    rs.hits   = hits_so_far;
    rs.misses = misses_so_far;
    rs.bytes  = bytes_so_far;
    rs.cycles = cycles_so_far;
    return rs;
  endfunction

  function automatic void check_field(string name, logic [sarcl_pkg::WORD_W-1:0] want,
                                      logic [sarcl_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Driver: item and cost channels, predictor updated on each transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sarcl_pkg::CFG_CACHE_COST: lookup_cost  = cfg_data_i;
          sarcl_pkg::CFG_MEM_COST:   miss_penalty = cfg_data_i;
          default: ;
        endcase
        cost_writes_done++;
      end
      if (start_i && !busy_o) expected_resps.push_back(cache_lookup(driven_req));
      // Hold the item while the block is busy.
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          driven_req = pending_reqs.pop_front();
          req_type_i     <= driven_req.req_type;
          byte_address_i <= driven_req.addr;
          access_size_i  <= driven_req.size;
          preload_word_i <= driven_req.word;
          start_i        <= 1'b1;
          if (sender_gaps_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
        end else begin
          start_i <= 1'b0;
        end
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (cost_writes.size() > 0) begin
          cost_write_t cw;
          cw = cost_writes.pop_front();
          cfg_index_i <= cw.index;
          cfg_data_i  <= cw.value;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      cache_resp_t want;
      results_seen++;
      if (expected_resps.size() == 0) begin
        mismatch_count++;
        $error("result with nothing expected: read_data %0h", read_data_o);
      end else begin
        want = expected_resps.pop_front();
        check_field("read_data", want.data, read_data_o);
        check_field("was_hit", sarcl_pkg::WORD_W'(want.hit), sarcl_pkg::WORD_W'(was_hit_o));
        check_field("hit_total", want.hits, hit_total_o);
        check_field("miss_total", want.misses, miss_total_o);
        check_field("byte_total", want.bytes, byte_total_o);
        check_field("cycle_total", want.cycles, cycle_total_o);
      end
    end
  end

  always @(posedge clk_i) begin
    elapsed_cycles++;
    if (elapsed_cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_preload(int addr, logic [sarcl_pkg::WORD_W-1:0] value);
    cache_req_t rq;
    rq.req_type = sarcl_pkg::REQ_PRELOAD;
    rq.addr     = sarcl_pkg::ADDR_W'(addr);
    rq.size     = sarcl_pkg::SIZE_W'($urandom_range(0, 3));
    rq.word     = value;
    word_loaded[(addr >> 2) % MEM_DEPTH] = 1'b1;
    pending_reqs.push_back(rq);
    items_queued++;
  endtask

  task automatic queue_read(int addr, logic [sarcl_pkg::SIZE_W-1:0] size);
    cache_req_t rq;
    rq.req_type = sarcl_pkg::REQ_READ;
    rq.addr     = sarcl_pkg::ADDR_W'(addr);
    rq.size     = size;
    rq.word     = $urandom;
    pending_reqs.push_back(rq);
    items_queued++;
  endtask

  // Reads go mostly to three tags per set so that lines get reused and evicted;
  // a block whose words are not loaded yet gets a preload instead.
  task automatic queue_random_item(int hot_tag);
    int blk;
    int w0;
    int w1;
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        blk = (hot_tag + $urandom_range(0, 2)) * SETS + $urandom_range(0, SETS - 1);
        queue_preload(blk * sarcl_pkg::LINE_BYTES
                      + $urandom_range(0, sarcl_pkg::LINE_BYTES - 1), $urandom);
      end else begin
        queue_preload($urandom_range(0, (1 << sarcl_pkg::ADDR_W) - 1), $urandom);
      end
    end else begin
      if ($urandom_range(0, 9) < 7)
        blk = (hot_tag + $urandom_range(0, 2)) * SETS + $urandom_range(0, SETS - 1);
      else
        blk = $urandom_range(0, NUM_BLOCKS - 1);
      w0 = (blk * 2) % MEM_DEPTH;
      w1 = (blk * 2 + 1) % MEM_DEPTH;
      if (!word_loaded[w0])
        queue_preload(w0 * 4 + $urandom_range(0, 3), $urandom);
      else if (!word_loaded[w1])
        queue_preload(w1 * 4 + $urandom_range(0, 3), $urandom);
      else
        queue_read(blk * sarcl_pkg::LINE_BYTES + $urandom_range(0, sarcl_pkg::LINE_BYTES - 1),
                   sarcl_pkg::SIZE_W'($urandom_range(0, 3)));
    end
  endtask

  task automatic wait_all_results();
    while (results_seen < items_queued) @(posedge clk_i);
  endtask

  task automatic write_costs(logic [sarcl_pkg::COST_W-1:0] lookup,
                             logic [sarcl_pkg::COST_W-1:0] penalty);
    int target;
    target = cost_writes_done + 2;
    cost_writes.push_back('{index: sarcl_pkg::CFG_CACHE_COST, value: lookup});
    cost_writes.push_back('{index: sarcl_pkg::CFG_MEM_COST, value: penalty});
    while (cost_writes_done < target) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int n;
    int pause_at;
    int hot_tag;
    logic [sarcl_pkg::COST_W-1:0] lookup;
    logic [sarcl_pkg::COST_W-1:0] penalty;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset costs: block 0 and 1 first, then a stale copy,
    // LRU eviction in set 0 and the top of the address space.
    queue_preload(9'h000, 32'h4433_2211);
    queue_preload(9'h007, 32'h8877_6655);
    queue_preload(9'h008, 32'hFFFF_FFFF);
    queue_preload(9'h00C, 32'h0000_0000);
    queue_read(9'h000, sarcl_pkg::SIZE_BYTE);
    queue_read(9'h007, sarcl_pkg::SIZE_BYTE);
    queue_read(9'h005, sarcl_pkg::SIZE_HALF);
    queue_read(9'h003, SIZE_WORD);
    queue_read(9'h006, SIZE_WIDE);
    queue_read(9'h00A, sarcl_pkg::SIZE_HALF);
    queue_preload(9'h000, 32'hDEAD_BEEF);
    queue_read(9'h001, sarcl_pkg::SIZE_BYTE);
    queue_preload(9'h010, 32'h1357_9BDF);
    queue_preload(9'h014, 32'h2468_ACE0);
    queue_read(9'h012, sarcl_pkg::SIZE_HALF);
    queue_preload(9'h020, 32'h0F0F_F0F0);
    queue_preload(9'h024, 32'hC3C3_3C3C);
    queue_read(9'h024, SIZE_WORD);
    queue_read(9'h000, sarcl_pkg::SIZE_BYTE);
    queue_preload(9'h1F8, 32'hA5A5_5A5A);
    queue_preload(9'h1FF, 32'h5A5A_A5A5);
    queue_read(9'h1FF, sarcl_pkg::SIZE_BYTE);
    queue_read(9'h1FE, SIZE_WIDE);
    wait_all_results();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin lookup = '0; penalty = '0; end
        1: begin lookup = '1; penalty = '1; end
        3: begin lookup = '0; penalty = '1; end
        default: begin
          lookup  = sarcl_pkg::COST_W'($urandom);
          penalty = sarcl_pkg::COST_W'($urandom);
        end
      endcase
      write_costs(lookup, penalty);
      // No idling in the last phase.
      sender_gaps_on = (phase != 4);
      hot_tag  = $urandom_range(0, TAGS - 3);
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off the sender until the block has drained.
        if (n == pause_at) wait_all_results();
        queue_random_item(hot_tag);
      end
      wait_all_results();
    end

    repeat (LATENCY + 6) @(posedge clk_i);
    if (mismatch_count == 0 && expected_resps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sarcl_pkg.sv
rtl/set_assoc_read_cache_lru_core.sv
tb/set_assoc_read_cache_lru_core_test.sv
